@@ sv/wfs_pkg.sv @@
// Shared types, codes and constants for the wall-follow sequencer.
// No dependencies; imported by wall_follow_sequencer.

package wfs_pkg;

    // Default width of the phase and bump timers
    localparam int TIMER_BITS_DEF = 16;

    // Payload widths
    localparam int SPEED_W  = 10;
    localparam int CALC_W   = 12;
    localparam int LEVEL_W  = 10;
    localparam int CSPEED_W = 9;
    localparam int WIN_W    = 16;
    localparam int EL_W     = 8;
    localparam int COUNT_W  = 8;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 40;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Phase timing limits in milliseconds
    localparam int BACKOFF_MS  = 1000;
    localparam int SCAN_MS     = 2000;
    localparam int ALIGN_MS    = 2000;
    localparam int CORNER0_MS  = 1400;
    localparam int CORNER1_MS  = 1000;
    localparam int CORNER2_MS  = 1500;

    // Target levels
    localparam logic [LEVEL_W-1:0] TARGET_RESET = 10'd80;
    localparam logic [LEVEL_W-1:0] TARGET_BUMP  = 10'd10;

    // Register reset values
    localparam logic [CSPEED_W-1:0] FORWARD_RESET = 9'd200;
    localparam logic [CSPEED_W-1:0] ROTATE_RESET  = 9'd200;
    localparam logic [CSPEED_W-1:0] STEER_RESET   = 9'd75;
    localparam logic [LEVEL_W-1:0]  CAP_RESET     = 10'd120;
    localparam logic [LEVEL_W-1:0]  LOST_RESET    = 10'd5;
    localparam logic [WIN_W-1:0]    WINDOW_RESET  = 16'd300;

    // Wheel speed saturation bound
    localparam logic signed [CALC_W-1:0] SPEED_MAX = 12'sd500;
    localparam logic signed [CALC_W-1:0] SPEED_MIN = -12'sd500;

    // Reciprocal of 3 in 11 fractional bits, exact for magnitudes up to 1023
    localparam logic [19:0] DIV3_RECIP = 20'd683;
    localparam int          DIV3_SHIFT = 11;

    typedef enum logic [3:0] {
        PH_SEEK    = 4'd0,
        PH_BACKOFF = 4'd1,
        PH_SCAN    = 4'd2,
        PH_ALIGN   = 4'd3,
        PH_FOLLOW  = 4'd4,
        PH_C0      = 4'd5,
        PH_C1      = 4'd6,
        PH_C2      = 4'd7,
        PH_HALT    = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        REG_FORWARD = 3'd0,
        REG_ROTATE  = 3'd1,
        REG_STEER   = 3'd2,
        REG_CAP     = 3'd3,
        REG_LOST    = 3'd4,
        REG_WINDOW  = 3'd5
    } cfg_idx_t;

    // Clamp a wheel speed to +-500 and narrow it to the port width
    function automatic logic signed [SPEED_W-1:0] sat_speed(logic signed [CALC_W-1:0] v);
        logic signed [CALC_W-1:0] c;
        c = v;
        if (v > SPEED_MAX)
        begin
            c = SPEED_MAX;
        end
        else if (v < SPEED_MIN)
        begin
            c = SPEED_MIN;
        end
        return c[SPEED_W-1:0];
    endfunction

endpackage

@@ sv/wall_follow_sequencer.sv @@
// Top level of the wall-follow sequencer: stream ports, APB register file,
// input register, single-pass phase logic and result register. Uses wfs_pkg.
//
//  channel | group             | direction | contents
//  --------+-------------------+-----------+---------------------------------
//  sensor  | s_tvalid/s_tready | in        | one tick per transaction
//  command | m_tvalid/m_tready | out       | one result per tick
//  config  | psel/penable/...  | in/out    | six registers at 4*index
//
// One tick enters per cycle while the result side does not stall; its result
// is offered once it has passed the input register and then the result register.
// The whole tick is evaluated combinationally from the input register and the
// phase state.
// A stall on the result side holds the result register and the input register;
// the sensor side stays open while either register has room.
// Reset (rst_n low) returns the phase state and the registers to their defaults.

module wall_follow_sequencer #(
    parameter int TIMER_BITS = wfs_pkg::TIMER_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // sensor stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [0] bump_left, [1] bump_right, [11:2] wall_signal, [19:12] elapsed_ms,
    // [20] stop_request, [23:21] zero
    input  logic [wfs_pkg::IN_W-1:0]    s_tdata,
    // command stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [9:0] left_speed, [19:10] right_speed, [23:20] phase,
    // [33:24] wall_target, [39:34] zero
    output logic [wfs_pkg::OUT_W-1:0]   m_tdata,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wfs_pkg::ADDR_W-1:0]  paddr,
    input  logic [wfs_pkg::DATA_W-1:0]  pwdata,
    output logic [wfs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    import wfs_pkg::*;

    localparam int CMP_W = (TIMER_BITS > WIN_W) ? TIMER_BITS : WIN_W;
    localparam logic [TIMER_BITS-1:0] T_BACKOFF = TIMER_BITS'(BACKOFF_MS);
    localparam logic [TIMER_BITS-1:0] T_SCAN    = TIMER_BITS'(SCAN_MS);
    localparam logic [TIMER_BITS-1:0] T_ALIGN   = TIMER_BITS'(ALIGN_MS);
    localparam logic [TIMER_BITS-1:0] T_C0      = TIMER_BITS'(CORNER0_MS);
    localparam logic [TIMER_BITS-1:0] T_C1      = TIMER_BITS'(CORNER1_MS);
    localparam logic [TIMER_BITS-1:0] T_C2      = TIMER_BITS'(CORNER2_MS);

    // Configuration registers
    logic [CSPEED_W-1:0] forward_reg;
    logic [CSPEED_W-1:0] rotate_reg;
    logic [CSPEED_W-1:0] steer_reg;
    logic [LEVEL_W-1:0]  cap_reg;
    logic [LEVEL_W-1:0]  lost_reg;
    logic [WIN_W-1:0]    window_reg;

    // Phase state
    phase_t              phase_reg,  phase_next;
    logic [TIMER_BITS-1:0] ptimer_reg, ptimer_next;
    logic [TIMER_BITS-1:0] sbump_reg,  sbump_next;
    logic [COUNT_W-1:0]  repeat_reg, repeat_next;
    logic [LEVEL_W-1:0]  target_reg, target_next;

    // Input register
    logic                in_valid_reg, in_valid_next;
    logic                bump_reg;
    logic [LEVEL_W-1:0]  wall_reg;
    logic [EL_W-1:0]     el_reg;
    logic                stop_reg;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0]  left_reg,  left_next;
    logic [SPEED_W-1:0]  right_reg, right_next;
    logic [3:0]          phout_reg;
    logic [LEVEL_W-1:0]  tgout_reg;

    logic                advance;
    logic                s_take;
    logic                work;
    logic                cfg_wr;
    cfg_idx_t            cfg_idx;

    // Handshake control
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;
    assign work     = in_valid_reg && advance;

    assign in_valid_next  = s_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = work ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Register port decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_idx_t'(paddr[ADDR_W-1:2]);

    // Read back the addressed register
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_FORWARD: prdata = DATA_W'(forward_reg);
            REG_ROTATE:  prdata = DATA_W'(rotate_reg);
            REG_STEER:   prdata = DATA_W'(steer_reg);
            REG_CAP:     prdata = DATA_W'(cap_reg);
            REG_LOST:    prdata = DATA_W'(lost_reg);
            REG_WINDOW:  prdata = DATA_W'(window_reg);
            default:     prdata = '0;
        endcase
    end

    // Write the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forward_reg <= FORWARD_RESET;
            rotate_reg  <= ROTATE_RESET;
            steer_reg   <= STEER_RESET;
            cap_reg     <= CAP_RESET;
            lost_reg    <= LOST_RESET;
            window_reg  <= WINDOW_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_FORWARD: forward_reg <= pwdata[CSPEED_W-1:0];
                REG_ROTATE:  rotate_reg  <= pwdata[CSPEED_W-1:0];
                REG_STEER:   steer_reg   <= pwdata[CSPEED_W-1:0];
                REG_CAP:     cap_reg     <= pwdata[LEVEL_W-1:0];
                REG_LOST:    lost_reg    <= pwdata[LEVEL_W-1:0];
                REG_WINDOW:  window_reg  <= pwdata[WIN_W-1:0];
                default:     ;
            endcase
        end
    end

    // Evaluate one tick: stop and halt, timers, bump, then the phases in sequence
    always_comb
    begin
        logic [TIMER_BITS:0]        psum;
        logic [TIMER_BITS:0]        bsum;
        logic signed [CALC_W-1:0]   fwd;
        logic signed [CALC_W-1:0]   rot;
        logic signed [CALC_W-1:0]   l;
        logic signed [CALC_W-1:0]   r;
        logic signed [CALC_W-1:0]   err;
        logic [LEVEL_W-1:0]         mag;
        logic [19:0]                prod;
        logic signed [CALC_W-1:0]   quo;
        logic signed [CALC_W-1:0]   lim;
        logic signed [CALC_W-1:0]   diff;
        logic [LEVEL_W-1:0]         half;
        logic [CALC_W-1:0]          three_q;
        phase_t                     ph;
        logic [TIMER_BITS-1:0]      pt;
        logic [TIMER_BITS-1:0]      sb;
        logic [COUNT_W-1:0]         rb;
        logic [LEVEL_W-1:0]         tl;

        fwd = CALC_W'(signed'({1'b0, forward_reg}));
        rot = CALC_W'(signed'({1'b0, rotate_reg}));
        lim = CALC_W'(signed'({1'b0, steer_reg}));
        l   = '0;
        r   = '0;
        ph  = phase_reg;
        pt  = ptimer_reg;
        sb  = sbump_reg;
        rb  = repeat_reg;
        tl  = target_reg;

        psum    = '0;
        bsum    = '0;
        err     = '0;
        mag     = '0;
        prod    = '0;
        quo     = '0;
        diff    = '0;
        half    = '0;
        three_q = '0;

        if (stop_reg || phase_reg == PH_HALT)
        begin
            ph = PH_HALT;
        end
        else
        begin
            // Advance both timers, saturating
            psum = {1'b0, ptimer_reg} + (TIMER_BITS+1)'(el_reg);
            bsum = {1'b0, sbump_reg} + (TIMER_BITS+1)'(el_reg);
            pt = psum[TIMER_BITS] ? '1 : psum[TIMER_BITS-1:0];
            sb = bsum[TIMER_BITS] ? '1 : bsum[TIMER_BITS-1:0];

            // Handle a bump where bumps are seen
            if (bump_reg && (ph == PH_SEEK || ph == PH_FOLLOW || ph == PH_C0 ||
                             ph == PH_C1 || ph == PH_C2))
            begin
                if (CMP_W'(sb) < CMP_W'(window_reg))
                begin
                    rb = (rb == '1) ? rb : rb + 1'b1;
                end
                else
                begin
                    rb = '0;
                end
                pt = '0;
                if (rb != '0)
                begin
                    ph = PH_BACKOFF;
                end
                else
                begin
                    ph = PH_SCAN;
                    tl = TARGET_BUMP;
                end
            end

            // Seek: drive straight
            if (ph == PH_SEEK)
            begin
                l = fwd;
                r = fwd;
            end

            // Backoff: rotate left until the time is up
            if (ph == PH_BACKOFF)
            begin
                if (pt >= T_BACKOFF)
                begin
                    tl = (cap_reg < TARGET_BUMP) ? cap_reg : TARGET_BUMP;
                    sb = '0;
                    ph = PH_FOLLOW;
                end
                else
                begin
                    l = -rot;
                    r = rot;
                end
            end

            // Scan: rotate left and track the peak signal
            if (ph == PH_SCAN)
            begin
                if (pt < T_SCAN)
                begin
                    if (wall_reg > tl)
                    begin
                        tl = wall_reg;
                    end
                    l = -rot;
                    r = rot;
                end
                else
                begin
                    half = tl >> 1;
                    tl = (cap_reg < half) ? cap_reg : half;
                    ph = PH_ALIGN;
                    pt = '0;
                end
            end

            // Align: rotate right until the signal reaches 3/4 of the target or the time is up
            if (ph == PH_ALIGN)
            begin
                three_q = (CALC_W'(tl) + CALC_W'({tl, 1'b0})) >> 2;
                if (CALC_W'(wall_reg) >= three_q || pt >= T_ALIGN)
                begin
                    sb = '0;
                    ph = PH_FOLLOW;
                end
                else
                begin
                    l = rot;
                    r = -rot;
                end
            end

            // Outside-corner steps
            if (ph == PH_C0 || ph == PH_C1 || ph == PH_C2)
            begin
                if (wall_reg > lost_reg && ph != PH_C1)
                begin
                    ph = PH_FOLLOW;
                end
                else if (ph == PH_C0)
                begin
                    if (pt > T_C0)
                    begin
                        ph = PH_C1;
                        pt = '0;
                        l = rot;
                        r = -rot;
                    end
                    else
                    begin
                        l = fwd;
                        r = fwd;
                    end
                end
                else if (ph == PH_C1)
                begin
                    if (pt > T_C1)
                    begin
                        ph = PH_C2;
                        pt = '0;
                        l = fwd;
                        r = fwd;
                    end
                    else
                    begin
                        l = rot;
                        r = -rot;
                    end
                end
                else
                begin
                    if (pt > T_C2)
                    begin
                        ph = PH_FOLLOW;
                    end
                    else
                    begin
                        l = fwd;
                        r = fwd;
                    end
                end
            end

            // Follow: clamped proportional steer, corner when the wall is lost
            if (ph == PH_FOLLOW)
            begin
                // Proportional correction: (target - wall) / 3, truncated toward zero,
                // taken from the target as it stands after this tick's earlier phases
                err  = CALC_W'(signed'({2'b00, tl})) - CALC_W'(signed'({2'b00, wall_reg}));
                mag  = err[CALC_W-1] ? LEVEL_W'(-err) : LEVEL_W'(err);
                prod = 20'(mag) * DIV3_RECIP;
                quo  = CALC_W'(prod[19:DIV3_SHIFT]);
                diff = err[CALC_W-1] ? -quo : quo;
                if (diff > lim)
                begin
                    diff = lim;
                end
                else if (diff < -lim)
                begin
                    diff = -lim;
                end
                l = fwd + diff;
                r = fwd - diff;
                if (wall_reg < lost_reg)
                begin
                    ph = PH_C0;
                    pt = '0;
                    l = fwd;
                    r = fwd;
                end
            end
        end

        phase_next  = ph;
        ptimer_next = pt;
        sbump_next  = sb;
        repeat_next = rb;
        target_next = tl;
        left_next   = sat_speed(l);
        right_next  = sat_speed(r);
    end

    // Handshake and phase state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SEEK;
            ptimer_reg    <= '0;
            sbump_reg     <= '0;
            repeat_reg    <= '0;
            target_reg    <= TARGET_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (work)
            begin
                phase_reg  <= phase_next;
                ptimer_reg <= ptimer_next;
                sbump_reg  <= sbump_next;
                repeat_reg <= repeat_next;
                target_reg <= target_next;
            end
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            bump_reg <= s_tdata[0] | s_tdata[1];
            wall_reg <= s_tdata[11:2];
            el_reg   <= s_tdata[19:12];
            stop_reg <= s_tdata[20];
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (work)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            phout_reg <= phase_next;
            tgout_reg <= target_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, tgout_reg, phout_reg, right_reg, left_reg};

endmodule
